@@ hdl/amix_pkg.sv @@
// amix_pkg: shared widths, constants and types for the adaptive gain mixer.
// No dependencies; imported by every module of the mixer.
package amix_pkg;

  // Source lanes and field widths
  localparam int MAX_SOURCES    = 8;
  localparam int SAMPLE_W       = 16;
  localparam int COUNT_W        = 4;
  localparam int SUM_W          = SAMPLE_W + $clog2(MAX_SOURCES);

  // Gain format: unsigned Q1.GAIN_FRAC_BITS
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
  localparam int RECOVER_SHIFT  = 5;

  // Datapath widths after the multiplier
  localparam int PROD_W         = SUM_W + GAIN_W + 1;
  localparam int SCALED_W       = PROD_W - GAIN_FRAC_BITS;
  localparam int REM_W          = SCALED_W + 1;
  localparam int ITER_W         = $clog2(GAIN_FRAC_BITS + 1);

  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1) << GAIN_FRAC_BITS;

  localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] PCM_MIN = 16'sh8000;

  // One lane's contribution to the sum
  typedef logic signed [SUM_W-1:0] lane_val_t;

  // Request to the gain divider
  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] num;
    logic [SCALED_W-1:0] den;
  } div_req_t;

endpackage

@@ hdl/amix_lane.sv @@
// amix_lane: one source lane; gates its sample by the active count and
// sign-extends it to sum width. Depends on amix_pkg.
module amix_lane
  import amix_pkg::*;
(
  input  logic                       clk,
  input  logic                       load,
  input  logic [COUNT_W-1:0]         lane_id,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [COUNT_W-1:0]         active_sources,
  output lane_val_t                  lane_val
);

  // Lanes at or past the active count contribute zero
  always_ff @(posedge clk) begin
    if (load) begin
      lane_val <= (active_sources > lane_id) ? lane_val_t'(sample) : '0;
    end
  end

endmodule

@@ hdl/amix_merge.sv @@
// amix_merge: adds the lane contributions into one registered sum.
// Depends on amix_pkg.
module amix_merge
  import amix_pkg::*;
(
  input  logic      clk,
  input  logic      load,
  input  lane_val_t lane_vals [MAX_SOURCES],
  output lane_val_t sum
);

  lane_val_t total;

  // Sum of all lanes; the width covers every lane at full scale
  always_comb begin
    total = '0;
    for (int i = 0; i < MAX_SOURCES; i++) begin
      total = total + lane_vals[i];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum <= total;
    end
  end

endmodule

@@ hdl/amix_div.sv @@
// amix_div: restoring divider for the gain recompute, one quotient bit
// per cycle, GAIN_FRAC_BITS quotient bits in all. Depends on amix_pkg.
module amix_div
  import amix_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  div_req_t                  req,
  output logic                      done,
  output logic [GAIN_FRAC_BITS-1:0] quotient
);

  logic [REM_W-1:0]    rem;
  logic [SCALED_W-1:0] den;
  logic [ITER_W-1:0]   iter;
  logic                running;
  logic [REM_W-1:0]    rem_sh;
  logic                take;

  // Numerator low bits are all zero, so only zeros shift in
  assign rem_sh = {rem[REM_W-2:0], 1'b0};
  assign take   = rem_sh >= REM_W'(den);

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      iter    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        iter    <= ITER_W'(GAIN_FRAC_BITS);
      end else if (running) begin
        iter <= iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= REM_W'(req.num);
      den      <= req.den;
      quotient <= '0;
    end else if (running) begin
      rem      <= take ? (rem_sh - REM_W'(den)) : rem_sh;
      quotient <= {quotient[GAIN_FRAC_BITS-2:0], take};
    end
  end

endmodule

@@ hdl/adaptive_gain_audio_mixer_unit.sv @@
// adaptive_gain_audio_mixer_unit: top level of the adaptive gain mixer.
// Path from input transfer: lane registers, sum, product, scaled value, output
// register; when the sum clips, the 16-step gain divider runs before the output.
// One item at a time: the next item is taken once the result is in the output
// register, which holds it meanwhile. Reset (rst, synchronous) sets gain to unity.
module adaptive_gain_audio_mixer_unit
  import amix_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_0,
  input  logic signed [SAMPLE_W-1:0] sample_1,
  input  logic signed [SAMPLE_W-1:0] sample_2,
  input  logic signed [SAMPLE_W-1:0] sample_3,
  input  logic signed [SAMPLE_W-1:0] sample_4,
  input  logic signed [SAMPLE_W-1:0] sample_5,
  input  logic signed [SAMPLE_W-1:0] sample_6,
  input  logic signed [SAMPLE_W-1:0] sample_7,
  input  logic [COUNT_W-1:0]         active_sources,
  input  logic                       first_of_block,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] mixed_sample,
  output logic                       clipped
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic signed [SCALED_W-1:0] LIM_HI = SCALED_W'(PCM_MAX);
  localparam logic signed [SCALED_W-1:0] LIM_LO = SCALED_W'(PCM_MIN);

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [GAIN_W-1:0]           gain;
  logic [GAIN_W-1:0]           gain_next;
  logic [GAIN_W-1:0]           gain_base;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    prod_full;
  logic signed [PROD_W-1:0]    prod_adj;
  logic signed [SCALED_W-1:0]  scaled_c;
  logic signed [SCALED_W-1:0]  scaled;
  logic                        hi_c;
  logic                        lo_c;
  logic                        clip_hi;
  logic                        clip_lo;
  logic signed [SAMPLE_W-1:0]  samples [MAX_SOURCES];
  lane_val_t                   lane_vals [MAX_SOURCES];
  lane_val_t                   sum;
  logic signed [GAIN_W:0]      gain_s;
  logic                        in_xfer;
  logic                        out_load;
  div_req_t                    div_req;
  logic                        div_done;
  logic [GAIN_FRAC_BITS-1:0]   quotient;

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;
  assign samples[4] = sample_4;
  assign samples[5] = sample_5;
  assign samples[6] = sample_6;
  assign samples[7] = sample_7;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // Source lanes
  for (genvar i = 0; i < MAX_SOURCES; i++) begin : g_lane
    amix_lane u_lane (
      .clk            (clk),
      .load           (in_xfer),
      .lane_id        (COUNT_W'(i)),
      .sample         (samples[i]),
      .active_sources (active_sources),
      .lane_val       (lane_vals[i])
    );
  end

  // Merge of lane contributions
  amix_merge u_merge (
    .clk       (clk),
    .load      (state == S_SUM),
    .lane_vals (lane_vals),
    .sum       (sum)
  );

  // Gain multiply
  assign gain_s    = $signed({1'b0, gain});
  assign prod_full = sum * gain_s;

  // Scale back by unity, truncating toward zero, and check the limits
  assign prod_adj = prod + (prod[PROD_W-1] ? PROD_W'(GAIN_UNITY - 1'b1) : '0);
  assign scaled_c = prod_adj[PROD_W-1:GAIN_FRAC_BITS];
  assign hi_c     = scaled_c > LIM_HI;
  assign lo_c     = scaled_c < LIM_LO;

  // Gain recompute on clip: limit * unity / |scaled|
  always_comb begin
    div_req.start = (state == S_SCALE) && (hi_c || lo_c);
    div_req.num   = hi_c ? SAMPLE_W'(PCM_MAX) : $unsigned(PCM_MIN);
    div_req.den   = hi_c ? $unsigned(scaled_c) : $unsigned(-scaled_c);
  end

  amix_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  // Gain update with recovery toward unity
  always_comb begin
    gain_base = (clip_hi || clip_lo) ? GAIN_W'(quotient) : gain;
    gain_next = gain_base;
    if (gain_base < GAIN_UNITY) begin
      gain_next = gain_base + ((GAIN_UNITY - gain_base) >> RECOVER_SHIFT);
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_xfer) state_next = S_SUM;
      S_SUM:   state_next = S_MUL;
      S_MUL:   state_next = S_SCALE;
      S_SCALE: state_next = (hi_c || lo_c) ? S_DIV : S_DONE;
      S_DIV:   if (div_done) state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gain      <= GAIN_UNITY;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_xfer && first_of_block) begin
        gain <= GAIN_UNITY;
      end else if (out_load) begin
        gain <= gain_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= prod_full;
    end
    if (state == S_SCALE) begin
      scaled  <= scaled_c;
      clip_hi <= hi_c;
      clip_lo <= lo_c;
    end
    if (out_load) begin
      mixed_sample <= clip_hi ? PCM_MAX : (clip_lo ? PCM_MIN : scaled[SAMPLE_W-1:0]);
      clipped      <= clip_hi || clip_lo;
    end
  end

`ifndef ASSERT_OFF
  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    gain <= GAIN_UNITY)
    else $error("gain above unity");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (mixed_sample == PCM_MAX || mixed_sample == PCM_MIN))
    else $error("clipped result not at a limit");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_SUM)
    else $error("input transfer did not start the sum stage");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");
`endif

endmodule
